// ===== rtl/rcq_pkg.sv =====
package rcq_pkg;

  // Word width of the stored entries and of the result data.
  localparam int unsigned DataW = 32;

  // Default number of ring slots.
  localparam int unsigned DepthDef = 16;

  typedef enum logic [2:0] {
    CMD_ENQ  = 3'd0,
    CMD_DEQ  = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_DUMP = 3'd3,
    CMD_REV  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// ===== rtl/reversible_circular_queue.sv =====
// Reversible circular queue. A bounded first-in first-out queue of signed
// 32-bit words kept in a ring of DEPTH slots, with a front index, an entry
// count and a direction bit. Each input word carries a command in tuser and,
// for enqueue, the word to append in tdata. Enqueue, reverse and any refused
// command produce their single result in the cycle after acceptance; the
// reversal only moves the front index to the rear entry and flips the
// direction bit, so no stored word moves. Dequeue and peek fetch the front
// word from the slot RAM, which delivers it in the cycle after its address is
// presented, and pass it on through the output register. A dump of N
// entries makes one RAM read per entry, overlapped with handing the previous
// entry to the output register. The block takes one command at a time; a new
// command is accepted once the previous one has produced all its results and
// the output register is free or being drained in the same cycle. Unused
// command codes are accepted and produce nothing. The slot RAM needs no
// clearing after reset, since only occupied slots are ever read.
module reversible_circular_queue
  import rcq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Command side.
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic [2:0]       s_axis_tuser_i,  // [2:0] command
  // Result side.
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o,  // [31:0] word
  output logic [1:0]       m_axis_tuser_o,  // [1:0] status
  output logic             m_axis_tlast_o
);

  // Slot index width, count width (holds DEPTH itself) and a width for
  // index sums, which stay below twice DEPTH.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  // Slot that lies off places from base, walking forward or backward around
  // the ring. base < DEPTH and off <= DEPTH, so one conditional subtract wraps.
  function automatic logic [AW-1:0] slot_at(logic [AW-1:0] base,
                                            logic [CW-1:0] off,
                                            logic          back);
    logic [SW-1:0] b;
    logic [SW-1:0] o;
    logic [SW-1:0] s;
    b = {{(SW-AW){1'b0}}, base};
    o = {{(SW-CW){1'b0}}, off};
    s = back ? (b + DepthS - o) : (b + o);
    if (s >= DepthS) begin
      s = s - DepthS;
    end
    return s[AW-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic             back_q, back_d;
  // Next slot to read during a dump, and the number of results still to
  // come after the one whose data sits in the RAM output.
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    rem_q, rem_d;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_word_q, out_word_d;
  status_e          out_status_q, out_status_d;
  logic             out_last_q, out_last_d;

  logic             in_acc;
  logic             out_free;
  cmd_e             cmd;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [DataW-1:0] ram_rdata;

  assign cmd             = cmd_e'(s_axis_tuser_i);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // The enqueue slot sits count places behind the front.
  assign ram_waddr = slot_at(head_q, count_q, back_q);

  rcq_ram #(
    .Width(DataW),
    .Depth(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(s_axis_tdata_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    back_d       = back_q;
    ptr_d        = ptr_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_word_d   = out_word_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd) inside
            CMD_ENQ: begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b1;
              if (count_q == DepthC) begin
                out_word_d   = '0;
                out_status_d = ST_FULL;
              end else begin
                ram_we       = 1'b1;
                count_d      = count_q + 1'b1;
                out_word_d   = s_axis_tdata_i;
                out_status_d = ST_OK;
              end
            end
            CMD_DEQ, CMD_PEEK, CMD_DUMP, CMD_REV: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_word_d   = '0;
                out_status_d = ST_EMPTY;
                out_last_d   = 1'b1;
              end else if (cmd == CMD_REV) begin
                // The rear entry becomes the front; the walk direction flips.
                head_d       = slot_at(head_q, count_q - 1'b1, back_q);
                back_d       = !back_q;
                out_valid_d  = 1'b1;
                out_word_d   = '0;
                out_status_d = ST_OK;
                out_last_d   = 1'b1;
              end else begin
                // Fetch the front word; it is delivered from S_READ.
                ram_re  = 1'b1;
                state_d = S_READ;
                ptr_d   = slot_at(head_q, CW'(1), back_q);
                rem_d   = (cmd == CMD_DUMP) ? (count_q - 1'b1) : '0;
                if (cmd == CMD_DEQ) begin
                  head_d  = slot_at(head_q, CW'(1), back_q);
                  count_d = count_q - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        // Hand over the fetched word and start the next read in the same
        // cycle; while the output stalls the RAM data simply holds.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = ram_rdata;
          out_status_d = ST_OK;
          out_last_d   = (rem_q == '0);
          if (rem_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q;
            ptr_d     = slot_at(ptr_q, CW'(1), back_q);
            rem_d     = rem_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      back_q       <= 1'b0;
      ptr_q        <= '0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      back_q       <= back_d;
      ptr_q        <= ptr_d;
      rem_q        <= rem_d;
      out_valid_q  <= out_valid_d;
      out_word_q   <= out_word_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // The entry count never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above ring size");

  // An accepted enqueue into a queue with room grows it by one.
  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == CMD_ENQ && count_q != DepthC)
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("enqueue did not grow the queue");

  // No command is taken while a read sequence is running.
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !s_axis_tready_o)
    else $error("command accepted while busy");

  // The final read of a sequence shows up as a last word.
  a_read_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && out_free && rem_q == '0)
      |=> (m_axis_tvalid_o && m_axis_tlast_o && state_q == S_IDLE))
    else $error("read sequence did not end with a last word");

endmodule

// ===== rtl/rcq_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// The read data holds its value while no read is enabled.
module rcq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
